@@ src/auto_backlight_level_filter_core_defines.svh @@
// auto_backlight_level_filter_core_defines.svh
// assertion macros for the backlight filter checker; clocked on aclk,
// disabled while aresetn is low
`ifndef AUTO_BACKLIGHT_LEVEL_FILTER_CORE_DEFINES_SVH
`define AUTO_BACKLIGHT_LEVEL_FILTER_CORE_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define ABLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ablf check failed");

// consequent must hold in the same cycle as the antecedent
`define ABLF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ablf check failed");

`endif

@@ src/ablf_pkg.sv @@
// ablf_pkg.sv
// shared types, constants and codes of the backlight level filter
// no dependencies
`default_nettype none

package ablf_pkg;

    // ring defaults
    localparam int RING_DEPTH_DEF = 32;

    // field widths
    localparam int MV_W     = 12;
    localparam int LVL_W    = 8;
    localparam int SLVL_W   = 5;
    localparam int WGT_W    = 16;
    localparam int ACT_W    = 3;
    localparam int ACC_W    = MV_W + 16;     // Q12.16 average
    localparam int MULA_W   = ACC_W + 1;     // signed difference operand
    localparam int MULB_W   = WGT_W + 1;     // signed weight or span operand
    localparam int PROD_W   = MULA_W + MULB_W;
    localparam int REM_W    = 17;            // magnitude of mapped numerator
    localparam int QUO_W    = 5;             // quotient stays below 31
    localparam int SH_W     = 3;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register reset values
    localparam logic [MV_W-1:0]   DARK_RST    = 12'd150;
    localparam logic [MV_W-1:0]   BRIGHT_RST  = 12'd2700;
    localparam logic [SLVL_W-1:0] FLOOR_RST   = 5'd1;
    localparam logic [SLVL_W-1:0] CEIL_RST    = 5'd29;
    localparam logic [WGT_W-1:0]  WEIGHT_RST  = 16'd26214;
    localparam logic [LVL_W-1:0]  MANUAL_RST  = 8'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DARK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SAMPLE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_AUTO = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TOGGLE   = 3'd4;

    // shared unit operations
    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_LOAD,
        ALU_EMA_MUL,
        ALU_EMA_ACC,
        ALU_MAP_MUL,
        ALU_DIV_INIT,
        ALU_DIV_STEP
    } alu_op_t;

    typedef struct packed {
        alu_op_t         op;
        logic [SH_W-1:0] shamt;
    } alu_ctl_t;

    typedef struct packed {
        logic [MV_W-1:0]         avg;
        logic signed [QUO_W:0]   quo;
    } alu_stat_t;

endpackage

`default_nettype wire

@@ src/ablf_ring.sv @@
// ablf_ring.sv
// sample ring memory with per-entry valid bits; unwritten entries read zero
// depends on nothing but its parameter
`default_nettype none

module ablf_ring #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic              vld_reg;

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
        end
    end

    // valid bits stand in for the cleared contents after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = vld_reg ? data_reg : '0;

endmodule

`default_nettype wire

@@ src/ablf_alu.sv @@
// ablf_alu.sv
// shared multiply / accumulate / divide-step unit of the level filter
// depends on ablf_pkg
`default_nettype none

module ablf_alu (
    input  wire logic                              aclk,
    input  wire ablf_pkg::alu_ctl_t                ctl,
    input  wire logic [ablf_pkg::MV_W-1:0]         sample,
    input  wire logic [ablf_pkg::WGT_W-1:0]        weight,
    input  wire logic [ablf_pkg::MV_W-1:0]         dark,
    input  wire logic [ablf_pkg::MV_W-1:0]         bright,
    input  wire logic [ablf_pkg::SLVL_W-1:0]       floor_lvl,
    input  wire logic [ablf_pkg::SLVL_W-1:0]       ceil_lvl,
    output ablf_pkg::alu_stat_t                    stat
);

    logic        [ablf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [ablf_pkg::PROD_W-1:0] prod_reg;
    logic        [ablf_pkg::REM_W-1:0]  rem_reg;
    logic        [ablf_pkg::QUO_W-1:0]  quo_reg;
    logic                               neg_reg;

    logic signed [ablf_pkg::MULA_W-1:0] ema_a;
    logic signed [ablf_pkg::MULA_W-1:0] mul_a;
    logic signed [ablf_pkg::MULB_W-1:0] mul_b;
    logic signed [ablf_pkg::PROD_W-1:0] prod_full;
    logic signed [ablf_pkg::SLVL_W:0]   span;
    logic        [ablf_pkg::MV_W-1:0]   avg;
    logic        [ablf_pkg::MV_W-1:0]   den;
    logic        [ablf_pkg::ACC_W:0]    acc_sum;
    logic        [ablf_pkg::PROD_W-1:0] prod_mag;
    logic        [ablf_pkg::REM_W-1:0]  den_sh;
    logic        [ablf_pkg::REM_W:0]    trial;

    assign avg   = acc_reg[ablf_pkg::ACC_W-1 -: ablf_pkg::MV_W];
    assign den   = bright - dark;
    assign span  = $signed({1'b0, ceil_lvl}) - $signed({1'b0, floor_lvl});
    assign ema_a = $signed({1'b0, sample, 16'h0000}) - $signed({1'b0, acc_reg});

    // operand select: ema difference times weight, or offset times level span
    always_comb begin
        if (ctl.op == ablf_pkg::ALU_MAP_MUL) begin
            mul_a = $signed({{(ablf_pkg::MULA_W-ablf_pkg::MV_W){1'b0}}, avg - dark});
            mul_b = $signed({{(ablf_pkg::MULB_W-ablf_pkg::SLVL_W-1){span[ablf_pkg::SLVL_W]}},
                             span});
        end else begin
            mul_a = ema_a;
            mul_b = $signed({1'b0, weight});
        end
    end

    assign prod_full = mul_a * mul_b;

    // acc + floor(w * diff / 2^16)
    assign acc_sum = {1'b0, acc_reg} + prod_reg[16 +: ablf_pkg::ACC_W+1];

    assign prod_mag = prod_reg[ablf_pkg::PROD_W-1] ? ablf_pkg::PROD_W'(-prod_reg)
                                                    : ablf_pkg::PROD_W'(prod_reg);
    assign den_sh   = ablf_pkg::REM_W'({5'b0_0000, den} << ctl.shamt);
    assign trial    = {1'b0, rem_reg} - {1'b0, den_sh};

    // datapath registers
    always_ff @(posedge aclk) begin
        case (ctl.op)
            ablf_pkg::ALU_LOAD: begin
                acc_reg  <= {sample, 16'h0000};
                prod_reg <= '0;
            end
            ablf_pkg::ALU_EMA_MUL,
            ablf_pkg::ALU_MAP_MUL: begin
                prod_reg <= prod_full;
            end
            ablf_pkg::ALU_EMA_ACC: begin
                acc_reg <= acc_sum[ablf_pkg::ACC_W-1:0];
            end
            ablf_pkg::ALU_DIV_INIT: begin
                rem_reg <= prod_mag[ablf_pkg::REM_W-1:0];
                neg_reg <= prod_reg[ablf_pkg::PROD_W-1];
                quo_reg <= '0;
            end
            ablf_pkg::ALU_DIV_STEP: begin
                if (!trial[ablf_pkg::REM_W]) begin
                    rem_reg              <= trial[ablf_pkg::REM_W-1:0];
                    quo_reg[ctl.shamt]   <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // truncation toward zero: sign applied to the magnitude quotient
    assign stat.avg = avg;
    assign stat.quo = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

`default_nettype wire

@@ src/auto_backlight_level_filter_core.sv @@
// auto_backlight_level_filter_core.sv
// top level: command handling, sequencer over the sample ring, result word
// depends on ablf_pkg, ablf_ring, ablf_alu
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | tuser action, tdata sample_mv, argument
//  m_      | out | m_tvalid / m_tready  | tdata duty, changed, auto, static, sensor
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a command word goes straight to the result register; a sample word takes
// one ring read and a multiply-accumulate pair per entry through the shared unit (the first entry loaded),
// then the map multiply and a 5-step divide when the average is inside the window.
// s_tready is high only while the sequencer is idle; one finished result may wait
// in the output register while the next word is already being worked on.
// aresetn clears the ring valid bits and the state, and resets the control and configuration registers.
`default_nettype none

module auto_backlight_level_filter_core #(
    parameter int RING_DEPTH = ablf_pkg::RING_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ablf_pkg::S_TDATA_W-1:0]    s_tdata,  // sample_mv[11:0] argument[19:12]
    input  wire logic [ablf_pkg::S_TUSER_W-1:0]    s_tuser,  // action[2:0]
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [ablf_pkg::M_TDATA_W-1:0]    m_tdata,  // duty_level[7:0] duty_changed[8]
                                                             // auto_mode[9] static_level[17:10]
                                                             // sensor_level[22:18]
    // register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ablf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ablf_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_CMP,
        S_DINIT,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t                              state_reg;
    logic [PTR_W-1:0]                    wp_reg;
    logic [PTR_W-1:0]                    rp_reg;
    logic [PTR_W-1:0]                    cnt_reg;
    logic [ablf_pkg::SH_W-1:0]           bit_reg;
    logic                                auto_reg;
    logic [ablf_pkg::LVL_W-1:0]          manual_reg;
    logic [ablf_pkg::SLVL_W-1:0]         derived_reg;
    logic [ablf_pkg::LVL_W-1:0]          before_reg;

    logic [ablf_pkg::MV_W-1:0]           dark_reg;
    logic [ablf_pkg::MV_W-1:0]           bright_reg;
    logic [ablf_pkg::SLVL_W-1:0]         floor_reg;
    logic [ablf_pkg::SLVL_W-1:0]         ceil_reg;
    logic [ablf_pkg::WGT_W-1:0]          weight_reg;

    logic                                m_valid_reg;
    logic [ablf_pkg::M_TDATA_W-1:0]      m_data_reg;

    logic [ablf_pkg::ACT_W-1:0]          in_action;
    logic [ablf_pkg::MV_W-1:0]           in_sample;
    logic [ablf_pkg::LVL_W-1:0]          in_arg;
    logic                                in_acc;
    logic                                out_free;
    logic [ablf_pkg::LVL_W-1:0]          duty_now;

    logic                                ring_wr;
    logic                                ring_rd;
    logic [ablf_pkg::MV_W-1:0]           ring_data;
    ablf_pkg::alu_ctl_t                  alu_ctl;
    ablf_pkg::alu_stat_t                 alu_stat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign in_action = s_tuser[ablf_pkg::ACT_W-1:0];
    assign in_sample = s_tdata[ablf_pkg::MV_W-1:0];
    assign in_arg    = s_tdata[ablf_pkg::MV_W +: ablf_pkg::LVL_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign duty_now  = auto_reg ? {3'b000, derived_reg} : manual_reg;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    // ring access: write on sample accept, one read per entry walk step
    assign ring_wr = in_acc && (in_action == ablf_pkg::ACT_SAMPLE);
    assign ring_rd = (state_reg == S_RD) || (state_reg == S_MUL);

    ablf_ring #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (ablf_pkg::MV_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ring_wr),
        .wr_addr (wp_reg),
        .wr_data (in_sample),
        .rd_en   (ring_rd),
        .rd_addr (rp_reg),
        .rd_data (ring_data)
    );

    // shared unit control from the sequencer state
    always_comb begin
        alu_ctl.op    = ablf_pkg::ALU_NOP;
        alu_ctl.shamt = bit_reg;
        unique case (state_reg)
            S_MUL:   alu_ctl.op = (cnt_reg == '0) ? ablf_pkg::ALU_LOAD : ablf_pkg::ALU_EMA_MUL;
            S_ACC:   alu_ctl.op = ablf_pkg::ALU_EMA_ACC;
            S_CMP:   alu_ctl.op = ablf_pkg::ALU_MAP_MUL;
            S_DINIT: alu_ctl.op = ablf_pkg::ALU_DIV_INIT;
            S_DIV:   alu_ctl.op = ablf_pkg::ALU_DIV_STEP;
            default: alu_ctl.op = ablf_pkg::ALU_NOP;
        endcase
    end

    ablf_alu u_alu (
        .aclk      (aclk),
        .ctl       (alu_ctl),
        .sample    (ring_data),
        .weight    (weight_reg),
        .dark      (dark_reg),
        .bright    (bright_reg),
        .floor_lvl (floor_reg),
        .ceil_lvl  (ceil_reg),
        .stat      (alu_stat)
    );

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg   <= ablf_pkg::DARK_RST;
            bright_reg <= ablf_pkg::BRIGHT_RST;
            floor_reg  <= ablf_pkg::FLOOR_RST;
            ceil_reg   <= ablf_pkg::CEIL_RST;
            weight_reg <= ablf_pkg::WEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ablf_pkg::REG_DARK:   dark_reg   <= cfg_data[ablf_pkg::MV_W-1:0];
                ablf_pkg::REG_BRIGHT: bright_reg <= cfg_data[ablf_pkg::MV_W-1:0];
                ablf_pkg::REG_FLOOR:  floor_reg  <= cfg_data[ablf_pkg::SLVL_W-1:0];
                ablf_pkg::REG_CEIL:   ceil_reg   <= cfg_data[ablf_pkg::SLVL_W-1:0];
                ablf_pkg::REG_WEIGHT: weight_reg <= cfg_data[ablf_pkg::WGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer, level state and result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            bit_reg     <= '0;
            auto_reg    <= 1'b0;
            manual_reg  <= ablf_pkg::MANUAL_RST;
            derived_reg <= '0;
            before_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // a word leaving with no new one behind it
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        before_reg <= duty_now;
                        state_reg  <= S_OUT;
                        unique case (in_action)
                            ablf_pkg::ACT_SAMPLE: begin
                                wp_reg    <= ptr_inc(wp_reg);
                                rp_reg    <= ptr_inc(wp_reg);
                                cnt_reg   <= '0;
                                state_reg <= S_RD;
                            end
                            ablf_pkg::ACT_SET:      manual_reg <= in_arg;
                            ablf_pkg::ACT_ADD:      manual_reg <= manual_reg + in_arg;
                            ablf_pkg::ACT_SET_AUTO: auto_reg   <= (in_arg != '0);
                            ablf_pkg::ACT_TOGGLE:   auto_reg   <= !auto_reg;
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    rp_reg    <= ptr_inc(rp_reg);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    // prefetch the next entry while the product settles
                    rp_reg    <= ptr_inc(rp_reg);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (cnt_reg == PTR_LAST) begin
                        state_reg <= S_CMP;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_CMP: begin
                    // clamp outside the window, else interpolate
                    if (alu_stat.avg <= dark_reg) begin
                        derived_reg <= floor_reg;
                        state_reg   <= S_OUT;
                    end else if (alu_stat.avg >= bright_reg) begin
                        derived_reg <= ceil_reg;
                        state_reg   <= S_OUT;
                    end else begin
                        state_reg <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    bit_reg   <= ablf_pkg::SH_W'(ablf_pkg::QUO_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (bit_reg == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                S_FIN: begin
                    derived_reg <= floor_reg + alu_stat.quo[ablf_pkg::SLVL_W-1:0];
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, derived_reg, manual_reg, auto_reg,
                                        (duty_now != before_reg), duty_now};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/ablf_checker.sv @@
// ablf_checker.sv
// port-level checks on the backlight filter top, bound to every instance
// depends on ablf_pkg and auto_backlight_level_filter_core_defines.svh
`default_nettype none

`include "auto_backlight_level_filter_core_defines.svh"

module ablf_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ablf_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result word stays offered and unchanged
    `ABLF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `ABLF_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

    // the sequencer is busy in the cycle after taking a word
    `ABLF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // duty level follows the mode: sensor level in auto, else static level
    `ABLF_ASSERT_SAME(a_duty_source, m_tvalid,
        m_tdata[9] ? (m_tdata[7:5] == 3'b000 && m_tdata[4:0] == m_tdata[22:18])
                   : (m_tdata[7:0] == m_tdata[17:10]))

endmodule

bind auto_backlight_level_filter_core ablf_checker u_ablf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
